FILE: design/kpd_pkg.sv
package kpd_pkg;

    // scanned columns, counted 0 .. KPD_NUM_COLUMNS-1
    localparam int unsigned KPD_NUM_COLUMNS = 3;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 8;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    // configuration register indexes
    localparam cfg_index_t CFG_DEBOUNCE_COUNT = cfg_index_t'(0);
    localparam cfg_index_t CFG_BEEP_TICKS     = cfg_index_t'(1);

    // register reset values
    localparam logic [7:0] DEBOUNCE_COUNT_RST = 8'd3;
    localparam logic [7:0] BEEP_TICKS_RST     = 8'd5;

    // release ticks needed before a press can be counted
    localparam logic [1:0] RELEASE_NEEDED = 2'd2;

    typedef struct packed {
        logic [7:0] debounce_count;
        logic [7:0] beep_ticks;
    } kpd_cfg_t;

    typedef struct packed {
        logic [7:0] beep_left;
        logic [3:0] seen_key;
        logic [3:0] prior_sample;
        logic [7:0] match_count;
        logic [1:0] release_ticks;
        logic [1:0] scan_column;
    } kpd_state_t;

    typedef struct packed {
        logic       buzzer_on;
        logic       press_valid;
        logic [1:0] press_row;
        logic [1:0] press_col;
        logic [3:0] press_key;
        logic [1:0] next_column;
    } kpd_result_t;

endpackage

FILE: design/kpd_if.sv
interface kpd_sample_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_bits;

    modport source (output valid, output row_bits, input ready);
    modport sink   (input valid, input row_bits, output ready);
endinterface

interface kpd_event_if;
    logic       valid;
    logic       ready;
    logic       buzzer_on;
    logic       press_valid;
    logic [1:0] press_row;
    logic [1:0] press_col;
    logic [3:0] press_key;
    logic [1:0] next_column;

    modport source (output valid, output buzzer_on, output press_valid, output press_row,
                    output press_col, output press_key, output next_column, input ready);
    modport sink   (input valid, input buzzer_on, input press_valid, input press_row,
                    input press_col, input press_key, input next_column, output ready);
endinterface

interface kpd_cfg_if;
    logic                  valid;
    logic                  ready;
    kpd_pkg::cfg_index_t   index;
    kpd_pkg::cfg_data_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/keypad_scan_debounce.sv
// Keypad scanner with debounce and beeper. Each item on samples is one scan tick carrying
// the four row levels of the column being scanned; each tick yields exactly one item on
// events with the buzzer level, an optional debounced press (row, column, key index) and
// the column to drive next. Items pass through an input register, one pass of shallow
// logic against the scanner state, and a result register: one item per clock cycle is
// sustained while events is ready. The input register lets a new tick enter while the
// previous result waits. Configuration writes are always ready; index 0 sets the
// debounce count, index 1 the beep length, other indexes are ignored.
module keypad_scan_debounce (
    input logic        clk,
    input logic        rst_n,
    kpd_sample_if.sink samples,
    kpd_event_if.source events,
    kpd_cfg_if.sink    cfg
);
    import kpd_pkg::*;

    logic        in_valid_reg;
    logic [3:0]  in_rows_reg;
    logic        out_valid_reg;
    kpd_result_t out_reg;
    kpd_cfg_t    cfg_reg;
    kpd_state_t  state_reg;
    kpd_state_t  state_next;
    kpd_result_t result_next;
    logic        advance;

    // tick moves into the result register when that register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || events.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_count <= DEBOUNCE_COUNT_RST;
            cfg_reg.beep_ticks     <= BEEP_TICKS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DEBOUNCE_COUNT: cfg_reg.debounce_count <= cfg.data;
                CFG_BEEP_TICKS:     cfg_reg.beep_ticks     <= cfg.data;
                default:            ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (samples.ready)
            in_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
            in_rows_reg <= samples.row_bits;
    end

    kpd_step u_step (
        .row_bits   (in_rows_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (events.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result_next;
    end

    assign events.valid       = out_valid_reg;
    assign events.buzzer_on   = out_reg.buzzer_on;
    assign events.press_valid = out_reg.press_valid;
    assign events.press_row   = out_reg.press_row;
    assign events.press_col   = out_reg.press_col;
    assign events.press_key   = out_reg.press_key;
    assign events.next_column = out_reg.next_column;

endmodule

FILE: design/kpd_step.sv
module kpd_step (
    input  logic [3:0]           row_bits,
    input  kpd_pkg::kpd_cfg_t    cfg,
    input  kpd_pkg::kpd_state_t  state,
    output kpd_pkg::kpd_state_t  state_next,
    output kpd_pkg::kpd_result_t result
);
    import kpd_pkg::*;

    logic [1:0] row;
    logic [3:0] key;
    logic [7:0] match_inc;
    logic [2:0] col_inc;

    // lowest active row
    always_comb
    begin
        if (row_bits[0])
            row = 2'd0;
        else if (row_bits[1])
            row = 2'd1;
        else if (row_bits[2])
            row = 2'd2;
        else
            row = 2'd3;
    end

    assign key       = {state.scan_column, row};
    assign match_inc = state.match_count + 8'd1;
    assign col_inc   = {1'b0, state.scan_column} + 3'd1;

    // one scan tick
    always_comb
    begin
        state_next = state;
        result     = '0;

        // beeper countdown
        if (state.beep_left != 8'd0)
        begin
            result.buzzer_on     = 1'b1;
            state_next.beep_left = state.beep_left - 8'd1;
        end

        if (row_bits != 4'd0)
        begin
            state_next.seen_key = key;
            if (state.release_ticks == RELEASE_NEEDED)
            begin
                if (key == state.prior_sample)
                begin
                    state_next.match_count = match_inc;
                    if (match_inc == cfg.debounce_count)
                    begin
                        state_next.beep_left     = cfg.beep_ticks;
                        result.press_valid       = 1'b1;
                        result.press_row         = row;
                        result.press_col         = state.scan_column;
                        result.press_key         = key;
                        state_next.match_count   = 8'd0;
                        state_next.release_ticks = 2'd0;
                        state_next.prior_sample  = 4'd0;
                    end
                end
                else
                begin
                    state_next.prior_sample = key;
                    state_next.match_count  = 8'd0;
                end
            end
            else
            begin
                state_next.release_ticks = 2'd0;
            end
        end
        else if (state.seen_key[3:2] == state.scan_column
                 && state.release_ticks != RELEASE_NEEDED)
        begin
            state_next.release_ticks = state.release_ticks + 2'd1;
        end

        // cyclic column advance
        if (col_inc >= 3'(KPD_NUM_COLUMNS))
            state_next.scan_column = 2'd0;
        else
            state_next.scan_column = col_inc[1:0];
        result.next_column = state_next.scan_column;
    end

endmodule
